FILE: hw/rtl/nfca_pkg.sv
// Shared types and constants for the next-fit cell allocator.
package nfca_pkg;

  localparam int unsigned AddrW      = 9;   // cell index width
  localparam int unsigned SizeW      = 10;  // heap size width
  localparam int unsigned WordW      = 32;  // used-map bits per memory row
  localparam int unsigned BitW       = 5;   // bit index within a row
  localparam int unsigned RowW       = 4;   // row index width
  localparam int unsigned Rows       = 16;  // rows covering all cells
  localparam logic [SizeW-1:0] InitialCells = 10'd8;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/next_fit_cell_allocator.sv
// Next-fit cell allocator over a used-bit map held in a 16 x 32 memory.
//
//  channel | dir | handshake                   | content
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser: func, tdata: cell_addr
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata: result fields
//
// Flow: a transaction is accepted in IDLE, evaluated in EVAL and its result
// loaded into the output register from DONE; free/check evaluate one row, allocate
// scans rows one per cycle, rescanning from row 0 after a doubling.
// Reset: map reads as all free via per-row valid flags, size 8, pointer 0.
// Stalls: a finished result waits in the output register; the next transaction
// is accepted once the block is idle, even while that result waits.
module next_fit_cell_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [8:0] cell_addr, [15:9] zero
  input  logic [nfca_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [8:0] result_addr, [9] full_error, [10] cell_valid,
  // [20:11] heap_size_out, [23:21] zero
  output logic [nfca_pkg::OutDataW-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------- state
  nfca_pkg::state_e                 state_q, state_d;
  nfca_pkg::func_e                  func_q;
  logic [nfca_pkg::AddrW-1:0]       addr_q;
  logic [nfca_pkg::RowW-1:0]        word_q, word_d;
  logic                             skip_q, skip_d;
  logic [nfca_pkg::SizeW-1:0]       ptr_q, ptr_d;    // 0..size, size = end of scan
  logic [nfca_pkg::SizeW-1:0]       size_q, size_d;

  // used map: one row of 32 cells per entry, rows not yet written read as free
  logic [nfca_pkg::WordW-1:0]       mem [nfca_pkg::Rows];
  logic [nfca_pkg::Rows-1:0]        row_vld_q;
  logic [nfca_pkg::WordW-1:0]       rd_data_q;
  logic [nfca_pkg::RowW-1:0]        rd_addr;
  logic                             we;
  logic [nfca_pkg::WordW-1:0]       wr_data;

  // result staging and output register
  logic [nfca_pkg::AddrW-1:0]       res_addr_q, res_addr_d;
  logic                             res_full_q, res_full_d;
  logic                             res_valid_q, res_valid_d;
  logic [nfca_pkg::SizeW-1:0]       res_size_q;
  logic                             out_valid_q;
  logic [nfca_pkg::OutDataW-1:0]    out_data_q;

  logic                             in_fire;
  logic                             out_load;
  logic                             eval_done;

  // ------------------------------------------------------ row evaluation
  logic [nfca_pkg::WordW-1:0]       lo_mask, hi_mask, cand;
  logic [nfca_pkg::BitW-1:0]        bit_idx;
  logic                             found;
  logic                             last_row;
  logic [nfca_pkg::AddrW-1:0]       free_idx;
  logic                             hit;
  logic [nfca_pkg::RowW-1:0]        word_inc;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == nfca_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  assign word_inc = word_q + 1'b1;

  always_comb begin
    // cells below the pointer in its own row are skipped
    if (word_q == ptr_q[nfca_pkg::AddrW-1:nfca_pkg::BitW] && !ptr_q[nfca_pkg::SizeW-1]) begin
      lo_mask = {nfca_pkg::WordW{1'b1}} << ptr_q[nfca_pkg::BitW-1:0];
    end else begin
      lo_mask = {nfca_pkg::WordW{1'b1}};
    end
    // heaps smaller than one row only use their lower bits
    if (size_q[nfca_pkg::SizeW-1:nfca_pkg::BitW] == '0) begin
      hi_mask = ({{(nfca_pkg::WordW-1){1'b0}}, 1'b1} << size_q[nfca_pkg::BitW-1:0])
                - {{(nfca_pkg::WordW-1){1'b0}}, 1'b1};
    end else begin
      hi_mask = {nfca_pkg::WordW{1'b1}};
    end
    cand = ~rd_data_q & lo_mask & hi_mask & {nfca_pkg::WordW{!skip_q}};
  end

  // lowest free cell of the row
  always_comb begin
    bit_idx = '0;
    for (int i = nfca_pkg::WordW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        bit_idx = nfca_pkg::BitW'(i);
      end
    end
  end

  assign found    = |cand;
  assign free_idx = {word_q, bit_idx};
  assign last_row = skip_q ||
                    ({1'b0, word_inc} >= size_q[nfca_pkg::SizeW-1:nfca_pkg::BitW]) ||
                    (word_inc == '0);
  assign hit      = ({1'b0, addr_q} < size_q) && rd_data_q[addr_q[nfca_pkg::BitW-1:0]];

  // ---------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nfca_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = nfca_pkg::ST_EVAL;
        end
      end
      nfca_pkg::ST_EVAL: begin
        if (eval_done) begin
          state_d = nfca_pkg::ST_DONE;
        end
      end
      nfca_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = nfca_pkg::ST_IDLE;
        end
      end
      default: state_d = nfca_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = (state_q == nfca_pkg::ST_IDLE);
    eval_done     = 1'b0;
    rd_addr       = word_q;
    we            = 1'b0;
    wr_data       = rd_data_q;
    word_d        = word_q;
    skip_d        = skip_q;
    ptr_d         = ptr_q;
    size_d        = size_q;
    res_addr_d    = res_addr_q;
    res_full_d    = res_full_q;
    res_valid_d   = res_valid_q;

    unique case (state_q)
      nfca_pkg::ST_IDLE: begin
        // row of the pointer for allocate, of the given cell otherwise
        if (nfca_pkg::func_e'(s_axis_tuser) == nfca_pkg::FUNC_ALLOC) begin
          rd_addr = ptr_q[nfca_pkg::AddrW-1:nfca_pkg::BitW];
        end else begin
          rd_addr = s_axis_tdata[nfca_pkg::AddrW-1:nfca_pkg::BitW];
        end
        // the row being read is the row written back
        word_d      = rd_addr;
        skip_d      = (ptr_q >= size_q);
        res_addr_d  = '0;
        res_full_d  = 1'b0;
        res_valid_d = 1'b0;
      end
      nfca_pkg::ST_EVAL: begin
        unique case (func_q)
          nfca_pkg::FUNC_ALLOC: begin
            if (found) begin
              eval_done  = 1'b1;
              we         = 1'b1;
              wr_data    = rd_data_q | ({{(nfca_pkg::WordW-1){1'b0}}, 1'b1} << bit_idx);
              ptr_d      = {1'b0, free_idx};
              res_addr_d = free_idx;
            end else if (!last_row) begin
              word_d  = word_inc;
              rd_addr = word_inc;
            end else if (size_q[nfca_pkg::SizeW-1]) begin
              // heap already at its maximum size, so no doubling: heap full
              eval_done  = 1'b1;
              ptr_d      = size_q;
              res_full_d = 1'b1;
              res_addr_d = nfca_pkg::AddrW'(size_q - 1'b1);
            end else begin
              // grow and rescan from cell 0; new upper cells are already free
              size_d  = size_q << 1;
              ptr_d   = '0;
              word_d  = '0;
              rd_addr = '0;
              skip_d  = 1'b0;
            end
          end
          nfca_pkg::FUNC_FREE: begin
            eval_done = 1'b1;
            if (hit) begin
              we      = 1'b1;
              wr_data = rd_data_q &
                        ~({{(nfca_pkg::WordW-1){1'b0}}, 1'b1} << addr_q[nfca_pkg::BitW-1:0]);
              ptr_d   = {1'b0, addr_q};
            end
          end
          nfca_pkg::FUNC_CHECK: begin
            eval_done   = 1'b1;
            res_valid_d = hit;
          end
          nfca_pkg::FUNC_NONE: begin
            eval_done = 1'b1;
          end
          default: eval_done = 1'b1;
        endcase
      end
      nfca_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ----------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfca_pkg::ST_IDLE;
      ptr_q       <= '0;
      size_q      <= nfca_pkg::InitialCells;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      size_q  <= size_d;
      if (we) begin
        row_vld_q[word_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= nfca_pkg::func_e'(s_axis_tuser);
      addr_q <= s_axis_tdata[nfca_pkg::AddrW-1:0];
    end
    word_q      <= word_d;
    skip_q      <= skip_d;
    res_addr_q  <= res_addr_d;
    res_full_q  <= res_full_d;
    res_valid_q <= res_valid_d;
    if (eval_done) begin
      res_size_q <= size_d;
    end
    if (out_load) begin
      out_data_q <= {3'b000, res_size_q, res_valid_q, res_full_q, res_addr_q};
    end
  end

  // used-map memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[word_q] <= wr_data;
    end
    rd_data_q <= row_vld_q[rd_addr] ? mem[rd_addr] : '0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------- assertions
  a_size_pow2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(size_q))
    else $error("heap size not a power of two");

  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= size_q)
    else $error("scan pointer beyond heap size");

  a_size_double : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q != size_d) |-> (size_d == (size_q << 1)) && (state_q == nfca_pkg::ST_EVAL))
    else $error("heap size changed other than by doubling");

  a_write_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == nfca_pkg::ST_EVAL) && eval_done)
    else $error("map write outside a finishing evaluation");

  a_full_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> m_axis_tdata[20])
    else $error("full reported below maximum heap size");

endmodule
